// ===== hdl/dhs_pkg.sv =====
// ============================================================================
// Disk head scheduler package
// Shared constants, types and helpers for the disk head scheduler.
// ============================================================================
package dhs_pkg;

    localparam int MaxRequests = 64;
    localparam int TrackBits   = 12;
    localparam int IdxBits     = $clog2(MaxRequests);
    localparam int CntBits     = $clog2(MaxRequests + 1);
    localparam int TravelBits  = 18;
    localparam logic [TravelBits-1:0] TravelMax = '1;

    typedef logic [TrackBits-1:0]  track_t;
    typedef logic [IdxBits-1:0]    idx_t;
    typedef logic [CntBits-1:0]    cnt_t;
    typedef logic [TravelBits-1:0] travel_t;

    typedef enum logic [1:0] {
        MODE_FCFS   = 2'd0,
        MODE_SSTF   = 2'd1,
        MODE_LOOK_L = 2'd2,
        MODE_LOOK_H = 2'd3
    } mode_t;

    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_START = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_WAIT,
        ST_PICK,
        ST_EMIT
    } state_t;

    function automatic track_t gap(input track_t a, input track_t b);
        gap = (a > b) ? track_t'(a - b) : track_t'(b - a);
    endfunction

endpackage

// ===== hdl/disk_head_scheduler_top.sv =====
// ============================================================================
// Disk head scheduler top level
// Stores a batch of track requests, then emits them in FCFS, SSTF or LOOK
// order with the total head travel on the final result.
// ============================================================================
//  channel   dir  handshake         payload
//  s_axis    in   tvalid/tready     tdata = track, tlast = last
//  m_axis    out  tvalid/tready     tdata = served_track, total_distance,
//                                   tlast = final_res, tuser = overflow
//  cfg       in   cfg_we            cfg_index, cfg_wdata
//
// Requests load at one per cycle into the request memory.
// After the last request, each SSTF or LOOK result takes a scan over the stored
// requests (one memory read per cycle), then the wait, pick and emit states.
// A LOOK batch adds one empty scan when a sweep group runs dry.
// FCFS results pass once through scan, wait, pick and emit (registered read).
// Reset is synchronous; no clearing pass is needed: each load writes a clear mark.
// A stalled result holds the scan; input is refused until the batch ends.
module disk_head_scheduler_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] track
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [11:0] served_track, [29:12] total_distance
    output logic        m_tlast,   // final_res
    output logic        m_tuser,   // [0] overflow
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [11:0] cfg_wdata
);

    dhs_pkg::mode_t   mode_reg;
    dhs_pkg::track_t  start_reg;
    dhs_pkg::state_t  state_reg, state_next;
    dhs_pkg::cnt_t    count_reg;
    dhs_pkg::cnt_t    scan_reg;
    dhs_pkg::track_t  head_reg;
    dhs_pkg::travel_t travel_reg;
    logic             drop_reg;
    dhs_pkg::cnt_t    done_reg;
    logic             phase_reg;     // LOOK: 0 first group, 1 second group
    logic             best_vld_reg;
    dhs_pkg::idx_t    best_idx_reg;
    dhs_pkg::track_t  best_trk_reg;
    dhs_pkg::track_t  best_key_reg;
    logic             rd_vld_reg;
    dhs_pkg::idx_t    rd_idx_reg;

    dhs_pkg::track_t  mem [dhs_pkg::MaxRequests];
    logic             mark_mem [dhs_pkg::MaxRequests];
    dhs_pkg::track_t  rd_data_reg;
    logic             rd_mark_reg;
    dhs_pkg::idx_t    rd_addr;

    logic in_acc, out_acc;
    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;
    assign s_tready = (state_reg == dhs_pkg::ST_LOAD);
    assign m_tvalid = (state_reg == dhs_pkg::ST_EMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= dhs_pkg::MODE_FCFS;
            start_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                dhs_pkg::CFG_MODE:  mode_reg  <= dhs_pkg::mode_t'(cfg_wdata[1:0]);
                dhs_pkg::CFG_START: start_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Memories: a load writes the track and a clear served mark, a pick sets
    // the mark; both are read once per scan cycle.
    assign rd_addr = (mode_reg == dhs_pkg::MODE_FCFS) ? done_reg[dhs_pkg::IdxBits-1:0]
                                                       : scan_reg[dhs_pkg::IdxBits-1:0];
    always_ff @(posedge aclk) begin
        if (in_acc && count_reg < dhs_pkg::cnt_t'(dhs_pkg::MaxRequests)) begin
            mem[count_reg[dhs_pkg::IdxBits-1:0]]      <= s_tdata[dhs_pkg::TrackBits-1:0];
            mark_mem[count_reg[dhs_pkg::IdxBits-1:0]] <= 1'b0;
        end else if (state_reg == dhs_pkg::ST_PICK && best_vld_reg) begin
            mark_mem[best_idx_reg] <= 1'b1;
        end
        rd_data_reg <= mem[rd_addr];
        rd_mark_reg <= mark_mem[rd_addr];
    end

    // Candidate evaluation on the registered read.
    logic            lower_grp, want_lower, eligible, better;
    dhs_pkg::track_t key;
    always_comb begin
        lower_grp  = rd_data_reg <= start_reg;
        want_lower = (mode_reg == dhs_pkg::MODE_LOOK_L) ? !phase_reg : phase_reg;
        eligible   = !rd_mark_reg;
        key        = dhs_pkg::gap(rd_data_reg, head_reg);
        better     = 1'b0;
        unique case (mode_reg)
            dhs_pkg::MODE_SSTF: better = !best_vld_reg || key < best_key_reg;
            dhs_pkg::MODE_LOOK_L, dhs_pkg::MODE_LOOK_H: begin
                eligible = eligible && (lower_grp == want_lower);
                better = !best_vld_reg || (want_lower ? rd_data_reg > best_trk_reg
                                                      : rd_data_reg < best_trk_reg);
            end
            default: better = 1'b1;
        endcase
    end

    logic scan_end;
    assign scan_end = (mode_reg == dhs_pkg::MODE_FCFS) ? 1'b1 : (scan_reg == count_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dhs_pkg::ST_LOAD: if (in_acc && s_tlast) state_next = dhs_pkg::ST_SCAN;
            dhs_pkg::ST_SCAN: if (scan_end) state_next = dhs_pkg::ST_WAIT;
            dhs_pkg::ST_WAIT: state_next = dhs_pkg::ST_PICK;
            dhs_pkg::ST_PICK: begin
                if (best_vld_reg)           state_next = dhs_pkg::ST_EMIT;
                else if (phase_reg == 1'b0 && mode_reg != dhs_pkg::MODE_FCFS &&
                         mode_reg != dhs_pkg::MODE_SSTF)
                                            state_next = dhs_pkg::ST_SCAN;
                else                        state_next = dhs_pkg::ST_LOAD;
            end
            dhs_pkg::ST_EMIT: if (out_acc)
                state_next = (done_reg == count_reg) ? dhs_pkg::ST_LOAD
                                                      : dhs_pkg::ST_SCAN;
            default: state_next = dhs_pkg::ST_LOAD;
        endcase
    end

    dhs_pkg::track_t   emit_trk_reg;
    dhs_pkg::travel_t  sum_ext;
    logic [dhs_pkg::TravelBits:0] sum_raw;
    assign sum_raw = {1'b0, travel_reg} +
                     (dhs_pkg::TravelBits+1)'(dhs_pkg::gap(best_trk_reg, head_reg));
    assign sum_ext = sum_raw[dhs_pkg::TravelBits] ? dhs_pkg::TravelMax
                                                  : sum_raw[dhs_pkg::TravelBits-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dhs_pkg::ST_LOAD;
            count_reg    <= '0;
            drop_reg     <= 1'b0;
            done_reg     <= '0;
            scan_reg     <= '0;
            phase_reg    <= 1'b0;
            best_vld_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
            head_reg     <= '0;
            travel_reg   <= '0;
        end else begin
            state_reg <= state_next;
            rd_vld_reg <= (state_reg == dhs_pkg::ST_SCAN) &&
                          ((mode_reg == dhs_pkg::MODE_FCFS) ? (done_reg != count_reg)
                                                             : !scan_end);
            unique case (state_reg)
                dhs_pkg::ST_LOAD: if (in_acc) begin
                    if (count_reg < dhs_pkg::cnt_t'(dhs_pkg::MaxRequests))
                        count_reg <= count_reg + 1'b1;
                    else
                        drop_reg <= 1'b1;
                    if (s_tlast) begin
                        head_reg     <= start_reg;
                        travel_reg   <= '0;
                        done_reg     <= '0;
                        scan_reg     <= '0;
                        phase_reg    <= 1'b0;
                        best_vld_reg <= 1'b0;
                    end
                end
                dhs_pkg::ST_SCAN: begin
                    if (!scan_end || mode_reg == dhs_pkg::MODE_FCFS)
                        rd_idx_reg <= rd_addr;
                    if (!scan_end) scan_reg <= scan_reg + 1'b1;
                end
                dhs_pkg::ST_PICK: begin
                    scan_reg <= '0;
                    if (best_vld_reg) begin
                        emit_trk_reg <= best_trk_reg;
                        travel_reg   <= sum_ext;
                        head_reg     <= best_trk_reg;
                        done_reg     <= done_reg + 1'b1;
                    end else if (state_next == dhs_pkg::ST_SCAN) begin
                        phase_reg <= 1'b1;
                    end
                end
                dhs_pkg::ST_EMIT: if (out_acc) begin
                    best_vld_reg <= 1'b0;
                    if (done_reg == count_reg) begin
                        count_reg <= '0;
                        done_reg  <= '0;
                        drop_reg  <= 1'b0;
                    end
                end
                default: ;
            endcase
            // Registered-read candidate update (SCAN and WAIT cycles).
            if (rd_vld_reg && eligible && better) begin
                best_vld_reg <= 1'b1;
                best_idx_reg <= rd_idx_reg;
                best_trk_reg <= rd_data_reg;
                best_key_reg <= key;
            end
        end
    end

    logic final_res;
    assign final_res = (done_reg == count_reg);
    assign m_tdata = {2'b00, (final_res ? travel_reg : dhs_pkg::travel_t'(0)), emit_trk_reg};
    assign m_tlast = final_res;
    assign m_tuser = drop_reg;

    a_no_load_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("load and emit overlap");
    a_done_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg <= count_reg) else $error("served more than stored");
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
        $stable(m_tuser)) else $error("stalled result changed");

endmodule
